// File: sv/aptbl_pkg.sv
// Shared definitions for the address pair table lookup/insert block.
// Holds field widths, result status codes and the controller/datapath interface types.
// Depends on nothing; the top level, controller and datapath import it.
package aptbl_pkg;

    // Default number of table entries.
    localparam int TABLE_DEPTH_DEF = 64;

    // Field widths.
    localparam int ADDR_W   = 32;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 6;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_FOUND    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture a new address pair and restart the scan
        logic scan;        // issue the next table read and compare the last one
        logic latch_hit;   // record the entry under compare as the match
        logic latch_miss;  // record that the scan ended without a match
        logic emit;        // load the result register, append on a miss to a table that is not full
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;         // entry under compare matches the pair
        logic scan_end;    // every stored entry has been compared
        logic out_free;    // result register can take a new transaction
    } stat_t;

endpackage

// File: sv/address_pair_table_lookup_insert.sv
// Top level of the address pair table lookup/insert block.
// Joins the controller state machine and the datapath with its entry RAM.
// Depends on aptbl_pkg, aptbl_ctrl, aptbl_dp and aptbl_ram.

// Each input transaction carries a pair of IPv4 addresses, which is compared
// against the recorded entries from index 0 upward; an entry matches when each
// byte of both addresses equals the same byte of either stored address. A hit
// returns status found with the lowest matching index, a miss appends the pair
// and returns inserted, and a miss on a full table returns full with index 0.
// One transaction is processed at a time. A miss on a table with N recorded
// entries, N at least one, makes N entry reads through the single read port of
// the entry RAM, compares the last entry read, sees the end of the scan and
// then loads the result register once the output is free. The next pair is
// accepted in the cycle after the result is loaded, even while that result is
// still stalled at the output.
module address_pair_table_lookup_insert #(
    parameter int TABLE_DEPTH = aptbl_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [aptbl_pkg::ADDR_W-1:0]     first_address,
    input  logic [aptbl_pkg::ADDR_W-1:0]     second_address,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [aptbl_pkg::STATUS_W-1:0]   status,
    output logic [aptbl_pkg::INDEX_W-1:0]    entry_index
);

    import aptbl_pkg::*;

    cmd_t  cmd;
    stat_t st;

    // Sequencing of accept, scan and result phases.
    aptbl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    // Entry store, compare logic and result register.
    aptbl_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .first_address  (first_address),
        .second_address (second_address),
        .status         (status),
        .entry_index    (entry_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall)
    );

endmodule

// File: sv/aptbl_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the entry store of the address pair table.
// Depends on nothing.
module aptbl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/aptbl_ctrl.sv
// Controller state machine of the address pair table lookup/insert block.
// Sequences accept, scan and result phases through command and status structs.
// Depends on aptbl_pkg.
module aptbl_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  aptbl_pkg::stat_t st,
    output aptbl_pkg::cmd_t  cmd
);

    import aptbl_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Next state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (st.hit || st.scan_end)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (st.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Input transactions are taken only between lookups.
    assign in_stall = (state_reg != ST_IDLE);

    // Commands to the datapath.
    always_comb
    begin
        cmd.load       = (state_reg == ST_IDLE) && in_valid;
        cmd.scan       = (state_reg == ST_SCAN);
        cmd.latch_hit  = (state_reg == ST_SCAN) && st.hit;
        cmd.latch_miss = (state_reg == ST_SCAN) && st.scan_end;
        cmd.emit       = (state_reg == ST_FINISH) && st.out_free;
    end

endmodule

// File: sv/aptbl_dp.sv
// Datapath of the address pair table lookup/insert block.
// Holds the pair registers, scan counters, entry count, entry RAM and result register.
// Depends on aptbl_pkg and aptbl_ram.
module aptbl_dp #(
    parameter int TABLE_DEPTH = aptbl_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  aptbl_pkg::cmd_t                  cmd,
    output aptbl_pkg::stat_t                 st,
    input  logic [aptbl_pkg::ADDR_W-1:0]     first_address,
    input  logic [aptbl_pkg::ADDR_W-1:0]     second_address,
    output logic [aptbl_pkg::STATUS_W-1:0]   status,
    output logic [aptbl_pkg::INDEX_W-1:0]    entry_index,
    output logic                             out_valid,
    input  logic                             out_stall
);

    import aptbl_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int ENT_W = 2 * ADDR_W;

    // True when every byte of addr equals the same byte of a or of b.
    function automatic logic bytes_covered(
        input logic [ADDR_W-1:0] addr,
        input logic [ADDR_W-1:0] a,
        input logic [ADDR_W-1:0] b
    );
        logic ok;
        ok = 1'b1;
        for (int k = 0; k < ADDR_W / 8; k++)
        begin
            if ((addr[8*k +: 8] != a[8*k +: 8]) && (addr[8*k +: 8] != b[8*k +: 8]))
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    logic [ADDR_W-1:0]   first_reg;
    logic [ADDR_W-1:0]   second_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    rd_idx_reg;
    logic                cmp_valid_reg;
    logic [IDX_W-1:0]    cmp_idx_reg;
    logic                res_hit_reg;
    logic [IDX_W-1:0]    res_idx_reg;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [INDEX_W-1:0]  index_reg;

    logic                issue;
    logic                full;
    logic                append;
    logic [ENT_W-1:0]    rd_data;
    logic [ADDR_W-1:0]   ent_first;
    logic [ADDR_W-1:0]   ent_second;

    // Entry store: first address in the upper half, second in the lower half.
    aptbl_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (append),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata ({first_reg, second_reg}),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (rd_data)
    );

    assign ent_first  = rd_data[ENT_W-1:ADDR_W];
    assign ent_second = rd_data[ADDR_W-1:0];

    // Scan and table occupancy status.
    assign issue  = cmd.scan && (rd_idx_reg < count_reg);
    assign full   = (count_reg == CNT_W'(TABLE_DEPTH));
    assign append = cmd.emit && !res_hit_reg && !full;

    always_comb
    begin
        st.hit      = cmp_valid_reg && bytes_covered(first_reg, ent_first, ent_second)
                                    && bytes_covered(second_reg, ent_first, ent_second);
        st.scan_end = !cmp_valid_reg && (rd_idx_reg >= count_reg);
        st.out_free = !out_valid_reg || !out_stall;
    end

    // Address pair capture.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            first_reg  <= first_address;
            second_reg <= second_address;
        end
    end

    // Scan pipeline control: read issue counter and compare stage valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg    <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            rd_idx_reg    <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else if (cmd.scan)
        begin
            cmp_valid_reg <= issue;
            if (issue)
            begin
                rd_idx_reg <= rd_idx_reg + CNT_W'(1);
            end
        end
    end

    // Index of the entry whose data is under compare.
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            cmp_idx_reg <= rd_idx_reg[IDX_W-1:0];
        end
    end

    // Lookup outcome.
    always_ff @(posedge clk)
    begin
        if (cmd.latch_hit)
        begin
            res_hit_reg <= 1'b1;
            res_idx_reg <= cmp_idx_reg;
        end
        else if (cmd.latch_miss)
        begin
            res_hit_reg <= 1'b0;
            res_idx_reg <= '0;
        end
    end

    // Entry count grows by one on every append.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (append)
        begin
            count_reg <= count_reg + CNT_W'(1);
        end
    end

    // Result register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            if (res_hit_reg)
            begin
                status_reg <= STATUS_FOUND;
                index_reg  <= INDEX_W'(res_idx_reg);
            end
            else if (full)
            begin
                status_reg <= STATUS_FULL;
                index_reg  <= '0;
            end
            else
            begin
                status_reg <= STATUS_INSERTED;
                index_reg  <= INDEX_W'(count_reg);
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign entry_index = index_reg;

endmodule
